@@ hdl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, masked while reset is held.
`define PTA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check on the rising clock edge, active through reset as well.
`define PTA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/pta_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pta_pkg
// Shared widths, register indexes and divider status type for the tile
// averaging block.
// ----------------------------------------------------------------------------
package pta_pkg;

  localparam int CFG_W          = 12;   // configuration data width
  localparam int CFG_IDX_W      = 2;    // configuration index width
  localparam int EDGE_W         = 12;   // tile edge width
  localparam int TILE_IDX_W     = 11;   // tile coordinate port width
  localparam int CHAN_W         = 8;    // color channel width
  localparam int CHAN_MAX       = 255;
  localparam int NUM_CH         = 3;
  localparam int REG_MAX        = 4095; // largest value a side register holds
  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_PIXEL_DENOM  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ hdl/pta_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pta_div
// Restoring radix-2 divider, one quotient bit per cycle while busy. done pulses
// for one cycle with the quotient valid and held.
// ----------------------------------------------------------------------------
module pta_div #(
  parameter int DVD_W = 30,
  parameter int DVS_W = 23
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [DVD_W-1:0]        dividend,
  input  logic [DVS_W-1:0]        divisor,
  output logic [DVD_W-1:0]        quotient,
  output pta_pkg::div_stat_t      stat
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] q_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             ge;
  logic [DVS_W-1:0] rem_nxt;
  logic [DVD_W-1:0] q_nxt;

  always_comb begin
    shifted = {rem_r, q_r[DVD_W-1]};
    diff    = shifted - {1'b0, dvs_r};
    ge      = shifted >= {1'b0, dvs_r};
    rem_nxt = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
    q_nxt   = {q_r[DVD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient  = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

@@ hdl/pixelate_tile_average.sv @@
`timescale 1ns / 1ps
// A pixel that closes no tile passes through accept, sum read and sum write.
// The first pixel of a frame adds a tile edge division (skipped if denom is 0).
// A pixel that closes a tile adds a pixel count multiply and then one shared
// bit-serial divider run per channel (SUM_W = 30 at default sizes).
// One request in flight at a time; the result register lets the next request in.
// Reset (rst_n low, synchronous): positions zero, tile edge one, registers 1/1/0.
// ----------------------------------------------------------------------------
// pixelate_tile_average
// Mosaic pixelation: per-tile channel sums kept for the current tile band in a
// column memory, truncated averages emitted as each tile completes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pixelate_tile_average #(
  parameter int MAX_WIDTH  = pta_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = pta_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pta_pkg::CHAN_W-1:0]        in_red,
  input  logic [pta_pkg::CHAN_W-1:0]        in_green,
  input  logic [pta_pkg::CHAN_W-1:0]        in_blue,

  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pta_pkg::TILE_IDX_W-1:0]    out_tile_col,
  output logic [pta_pkg::TILE_IDX_W-1:0]    out_tile_row,
  output logic [pta_pkg::EDGE_W-1:0]        out_tile_side,
  output logic [pta_pkg::CHAN_W-1:0]        out_avg_red,
  output logic [pta_pkg::CHAN_W-1:0]        out_avg_green,
  output logic [pta_pkg::CHAN_W-1:0]        out_avg_blue,
  output logic                              out_frame_end,

  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pta_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pta_pkg::CFG_W-1:0]         cfg_data
);

  localparam int EDGE_W   = pta_pkg::EDGE_W;
  localparam int CHAN_W   = pta_pkg::CHAN_W;
  localparam int NUM_CH   = pta_pkg::NUM_CH;
  localparam int REG_MAX  = pta_pkg::REG_MAX;
  localparam int W_LIM    = (MAX_WIDTH < REG_MAX) ? MAX_WIDTH : REG_MAX;
  localparam int H_LIM    = (MAX_HEIGHT < REG_MAX) ? MAX_HEIGHT : REG_MAX;
  localparam int SIDE_LIM = (W_LIM > H_LIM) ? W_LIM : H_LIM;
  localparam int CW       = $clog2(W_LIM);
  localparam int RW       = $clog2(H_LIM);
  localparam int CMP_W    = EDGE_W + 1;
  localparam int PROD_W   = 2 * EDGE_W;
  localparam longint CNT_MAX = longint'(SIDE_LIM) * longint'(SIDE_LIM);
  localparam int CNT_W    = $clog2(CNT_MAX + 1);
  localparam int SUM_W    = $clog2(CNT_MAX * pta_pkg::CHAN_MAX + 1);
  localparam int DVS_W    = (CNT_W > pta_pkg::CFG_W) ? CNT_W : pta_pkg::CFG_W;
  localparam int CH_W     = $clog2(NUM_CH);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_EDGE   = 9'b000000010,
    S_EWAIT  = 9'b000000100,
    S_READ   = 9'b000001000,
    S_ACC    = 9'b000010000,
    S_MUL    = 9'b000100000,
    S_DSTART = 9'b001000000,
    S_DWAIT  = 9'b010000000,
    S_EMIT   = 9'b100000000
  } state_t;

  state_t state_r;

  // configuration
  logic [pta_pkg::CFG_W-1:0] width_r, height_r, denom_r;

  // raster position and tile counters
  logic [CW-1:0]     c_r, cx_r, tc_r;
  logic [RW-1:0]     r_r, ry_r, tr_r;
  logic [EDGE_W-1:0] e_r;

  // per-request payload
  logic [CHAN_W-1:0]  pix_r [NUM_CH];
  logic [3*SUM_W-1:0] rd_r;
  logic [SUM_W-1:0]   sum_r [NUM_CH];
  logic [CHAN_W-1:0]  avg_r [NUM_CH];
  logic [EDGE_W-1:0]  tw_r, th_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [CW-1:0]      tcol_r;
  logic [RW-1:0]      trow_r;
  logic               flast_r;
  logic [CH_W-1:0]    ch_r;

  // result register
  logic                          out_valid_r;
  logic [pta_pkg::TILE_IDX_W-1:0] out_col_r, out_row_r;
  logic [EDGE_W-1:0]             out_side_r;
  logic [CHAN_W-1:0]             out_red_r, out_green_r, out_blue_r;
  logic                          out_fe_r;

  logic [3*SUM_W-1:0] mem [W_LIM];

  // divider hookup
  logic               div_start;
  logic [SUM_W-1:0]   div_dvd;
  logic [DVS_W-1:0]   div_dvs;
  logic [SUM_W-1:0]   div_quo;
  pta_pkg::div_stat_t div_stat;

  // ---------------------------------------------------------------------
  // geometry compares, all in CMP_W bits
  logic [CMP_W-1:0] ww, hh, ee, big, cw, rr, cxw, ryw;

  always_comb begin
    if (width_r == '0)                 ww = CMP_W'(1);
    else if (int'(width_r) > W_LIM)    ww = CMP_W'(W_LIM);
    else                               ww = CMP_W'(width_r);
    if (height_r == '0)                hh = CMP_W'(1);
    else if (int'(height_r) > H_LIM)   hh = CMP_W'(H_LIM);
    else                               hh = CMP_W'(height_r);
    big = (ww > hh) ? ww : hh;
    ee  = CMP_W'(e_r);
    cw  = CMP_W'(c_r);
    rr  = CMP_W'(r_r);
    cxw = CMP_W'(cx_r);
    ryw = CMP_W'(ry_r);
  end

  // next row from the current one
  logic [RW-1:0] r_adv, ry_adv, tr_adv;

  always_comb begin
    if (rr + CMP_W'(1) >= hh) begin
      r_adv  = '0;
      ry_adv = '0;
      tr_adv = '0;
    end else begin
      r_adv = r_r + 1'b1;
      if (ryw + CMP_W'(1) == ee) begin
        ry_adv = '0;
        tr_adv = tr_r + 1'b1;
      end else begin
        ry_adv = ry_r + 1'b1;
        tr_adv = tr_r;
      end
    end
  end

  // next column within the row
  logic [CW-1:0] c_adv, cx_adv, tc_adv;
  logic          col_wrap;

  always_comb begin
    c_adv    = c_r + 1'b1;
    col_wrap = (cw + CMP_W'(1) >= ww);
    if (cxw + CMP_W'(1) == ee) begin
      cx_adv = '0;
      tc_adv = tc_r + 1'b1;
    end else begin
      cx_adv = cx_r + 1'b1;
      tc_adv = tc_r;
    end
  end

  // position fix-up on accept, for geometry that shrank under the position
  logic [CW-1:0] pre_c, pre_cx, pre_tc;
  logic [RW-1:0] pre_r, pre_ry, pre_tr;
  logic          frame_start;

  always_comb begin
    pre_c  = c_r;
    pre_cx = cx_r;
    pre_tc = tc_r;
    pre_r  = r_r;
    pre_ry = ry_r;
    pre_tr = tr_r;
    priority if (rr >= hh) begin
      pre_c  = '0;
      pre_cx = '0;
      pre_tc = '0;
      pre_r  = '0;
      pre_ry = '0;
      pre_tr = '0;
    end else if (cw >= ww) begin
      pre_c  = '0;
      pre_cx = '0;
      pre_tc = '0;
      pre_r  = r_adv;
      pre_ry = ry_adv;
      pre_tr = tr_adv;
    end else begin
    end
    frame_start = (pre_c == '0) && (pre_r == '0);
  end

  // accumulate step
  logic             first_pix, last_col, last_row, frame_last;
  logic [SUM_W-1:0] rd_sum [NUM_CH];
  logic [SUM_W-1:0] sum_nxt [NUM_CH];
  logic [CMP_W-1:0] col_rem, row_rem;
  logic [EDGE_W-1:0] tw_nxt, th_nxt;
  logic [PROD_W-1:0] cnt_prod;

  always_comb begin
    first_pix  = (cx_r == '0) && (ry_r == '0);
    last_col   = (cxw + CMP_W'(1) == ee) || (cw + CMP_W'(1) == ww);
    last_row   = (ryw + CMP_W'(1) == ee) || (rr + CMP_W'(1) == hh);
    frame_last = (cw + CMP_W'(1) == ww) && (rr + CMP_W'(1) == hh);
    for (int i = 0; i < NUM_CH; i++) begin
      rd_sum[i]  = rd_r[(NUM_CH-1-i)*SUM_W +: SUM_W];
      sum_nxt[i] = first_pix ? SUM_W'(pix_r[i]) : rd_sum[i] + SUM_W'(pix_r[i]);
    end
    // tile start column is c - cx, start row is r - ry
    col_rem  = ww - (cw - cxw);
    row_rem  = hh - (rr - ryw);
    tw_nxt   = (col_rem > ee) ? e_r : EDGE_W'(col_rem);
    th_nxt   = (row_rem > ee) ? e_r : EDGE_W'(row_rem);
    cnt_prod = PROD_W'(tw_r) * PROD_W'(th_r);
  end

  // ---------------------------------------------------------------------
  assign div_start = ((state_r == S_EDGE) && (denom_r != '0)) || (state_r == S_DSTART);
  assign div_dvd   = (state_r == S_EDGE) ? SUM_W'(big) : sum_r[ch_r];
  assign div_dvs   = (state_r == S_EDGE) ? DVS_W'(denom_r) : DVS_W'(cnt_r);

  pta_div #(
    .DVD_W (SUM_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  // registers change only between requests; a pending write goes first
  assign in_ready  = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);

  logic in_acc, out_load;
  assign in_acc   = in_valid && in_ready;
  assign out_load = (state_r == S_EMIT) && (!out_valid_r || out_ready);

  // ---------------------------------------------------------------------
  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      width_r     <= pta_pkg::CFG_W'(1);
      height_r    <= pta_pkg::CFG_W'(1);
      denom_r     <= '0;
      c_r         <= '0;
      cx_r        <= '0;
      tc_r        <= '0;
      r_r         <= '0;
      ry_r        <= '0;
      tr_r        <= '0;
      e_r         <= EDGE_W'(1);
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          pta_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_data;
          pta_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_data;
          pta_pkg::REG_PIXEL_DENOM:  denom_r  <= cfg_data;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            c_r  <= pre_c;
            cx_r <= pre_cx;
            tc_r <= pre_tc;
            r_r  <= pre_r;
            ry_r <= pre_ry;
            tr_r <= pre_tr;
            state_r <= frame_start ? S_EDGE : S_READ;
          end
        end
        S_EDGE: begin
          if (denom_r == '0) begin
            e_r     <= EDGE_W'(1);
            state_r <= S_READ;
          end else begin
            state_r <= S_EWAIT;
          end
        end
        S_EWAIT: begin
          if (div_stat.done) begin
            e_r     <= (div_quo == '0) ? EDGE_W'(1) : EDGE_W'(div_quo);
            state_r <= S_READ;
          end
        end
        S_READ: state_r <= S_ACC;
        S_ACC: begin
          if (col_wrap) begin
            c_r  <= '0;
            cx_r <= '0;
            tc_r <= '0;
            r_r  <= r_adv;
            ry_r <= ry_adv;
            tr_r <= tr_adv;
          end else begin
            c_r  <= c_adv;
            cx_r <= cx_adv;
            tc_r <= tc_adv;
          end
          ch_r    <= '0;
          state_r <= (last_col && last_row) ? S_MUL : S_IDLE;
        end
        S_MUL: state_r <= S_DSTART;
        S_DSTART: state_r <= S_DWAIT;
        S_DWAIT: begin
          if (div_stat.done) begin
            ch_r    <= ch_r + 1'b1;
            state_r <= (ch_r == CH_W'(NUM_CH - 1)) ? S_EMIT : S_DSTART;
          end
        end
        S_EMIT: begin
          if (out_load) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // payload and sum memory
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pix_r[0] <= in_red;
      pix_r[1] <= in_green;
      pix_r[2] <= in_blue;
    end
    if (state_r == S_READ) begin
      rd_r <= mem[tc_r];
    end
    if (state_r == S_ACC) begin
      mem[tc_r] <= {sum_nxt[0], sum_nxt[1], sum_nxt[2]};
      for (int i = 0; i < NUM_CH; i++) begin
        sum_r[i] <= sum_nxt[i];
      end
      tw_r    <= tw_nxt;
      th_r    <= th_nxt;
      tcol_r  <= tc_r;
      trow_r  <= tr_r;
      flast_r <= frame_last;
    end
    if (state_r == S_MUL) begin
      cnt_r <= CNT_W'(cnt_prod);
    end
    if ((state_r == S_DWAIT) && div_stat.done) begin
      avg_r[ch_r] <= div_quo[CHAN_W-1:0];
    end
    if (out_load) begin
      out_col_r   <= pta_pkg::TILE_IDX_W'(tcol_r);
      out_row_r   <= pta_pkg::TILE_IDX_W'(trow_r);
      out_side_r  <= e_r;
      out_red_r   <= avg_r[0];
      out_green_r <= avg_r[1];
      out_blue_r  <= avg_r[2];
      out_fe_r    <= flast_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_tile_col  = out_col_r;
  assign out_tile_row  = out_row_r;
  assign out_tile_side = out_side_r;
  assign out_avg_red   = out_red_r;
  assign out_avg_green = out_green_r;
  assign out_avg_blue  = out_blue_r;
  assign out_frame_end = out_fe_r;

  // ---------------------------------------------------------------------
  logic div_wait, offs_ok;
  assign div_wait = (state_r == S_EWAIT) || (state_r == S_DWAIT);
  assign offs_ok  = (cxw < ee) && (ryw < ee);

  `PTA_ASSERT(a_edge_nonzero, clk, rst_n, e_r != '0, "tile edge register is zero")
  `PTA_ASSERT(a_idle_div_free, clk, rst_n, in_ready |-> !div_stat.busy, "divider busy while idle")
  `PTA_ASSERT(a_done_in_wait, clk, rst_n, div_stat.done |-> div_wait, "divider done out of wait")
  `PTA_ASSERT(a_offs_in_tile, clk, rst_n, (state_r == S_ACC) |-> offs_ok, "tile offset past edge")

endmodule
